[hdl/dbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbe_pkg: DES block encryption types, tables and bit-permutation functions
// DES numbers bits from 1 at the most significant end. Every table below uses
// that numbering, and the functions map it onto vector indexes.
// ----------------------------------------------------------------------------
package dbe_pkg;

   localparam int ROUNDS        = 16;
   localparam int HALF_KEY_BITS = 28;
   localparam int SUBKEY_BITS   = 48;
   localparam int CD_BITS       = 56;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } half_pair_type;

   typedef logic [ROUNDS-1:0][SUBKEY_BITS-1:0] subkey_array_type;

   localparam logic [7:0] IP_TAB [64] = '{
      8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
      8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
      8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
      8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
      8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

   localparam logic [7:0] FP_TAB [64] = '{
      8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
      8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
      8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
      8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
      8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
      8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
      8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
      8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25};

   localparam logic [7:0] E_TAB [48] = '{
      8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,
      8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
      8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13,
      8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
      8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21,
      8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
      8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
      8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

   localparam logic [7:0] P_TAB [32] = '{
      8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
      8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
      8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
      8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25};

   localparam logic [7:0] PC1_TAB [56] = '{
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
      8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
      8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
      8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
      8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
      8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
      8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
      8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

   localparam logic [7:0] PC2_TAB [48] = '{
      8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
      8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
      8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
      8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
      8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
      8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
      8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
      8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

   // Total left rotation of C and D after each round, summed over the
   // per-round shifts of one or two.
   localparam logic [4:0] ROT_SUM_TAB [ROUNDS] = '{
      5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   function automatic logic [63:0] perm_ip(input logic [63:0] x);
      logic [63:0] res;
      res = '0;
      for (int i = 0; i < 64; i++) begin
         res[6'(63 - i)] = x[6'(64 - int'(IP_TAB[i]))];
      end
      return res;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] x);
      logic [63:0] res;
      res = '0;
      for (int i = 0; i < 64; i++) begin
         res[6'(63 - i)] = x[6'(64 - int'(FP_TAB[i]))];
      end
      return res;
   endfunction

   function automatic logic [47:0] perm_e(input logic [31:0] x);
      logic [47:0] res;
      res = '0;
      for (int i = 0; i < 48; i++) begin
         res[6'(47 - i)] = x[5'(32 - int'(E_TAB[i]))];
      end
      return res;
   endfunction

   function automatic logic [31:0] perm_p(input logic [31:0] x);
      logic [31:0] res;
      res = '0;
      for (int i = 0; i < 32; i++) begin
         res[5'(31 - i)] = x[5'(32 - int'(P_TAB[i]))];
      end
      return res;
   endfunction

   function automatic logic [CD_BITS-1:0] perm_pc1(input logic [63:0] x);
      logic [CD_BITS-1:0] res;
      res = '0;
      for (int i = 0; i < CD_BITS; i++) begin
         res[6'(CD_BITS - 1 - i)] = x[6'(64 - int'(PC1_TAB[i]))];
      end
      return res;
   endfunction

   function automatic logic [SUBKEY_BITS-1:0] perm_pc2(input logic [CD_BITS-1:0] x);
      logic [SUBKEY_BITS-1:0] res;
      res = '0;
      for (int i = 0; i < SUBKEY_BITS; i++) begin
         res[6'(SUBKEY_BITS - 1 - i)] = x[6'(CD_BITS - int'(PC2_TAB[i]))];
      end
      return res;
   endfunction

   // Left rotation of a 28-bit half by a fixed amount of 0 to 28.
   function automatic logic [HALF_KEY_BITS-1:0] rotl28(input logic [HALF_KEY_BITS-1:0] v,
                                                       input logic [4:0] s);
      logic [2*HALF_KEY_BITS-1:0] dbl;
      dbl = {v, v};
      return dbl[6'(2*HALF_KEY_BITS - 1 - int'(s)) -: HALF_KEY_BITS];
   endfunction

   function automatic logic [3:0] sbox(input int box, input logic [5:0] six);
      return SBOX_TAB[box][{six[5], six[0], six[4:1]}];
   endfunction

endpackage
`default_nettype wire

[hdl/dbe_key_sched.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbe_key_sched: DES key schedule register
// Expands a written key into all sixteen round subkeys at write time and
// holds them, so the datapath sees ready subkeys from the next cycle on.
// ----------------------------------------------------------------------------
module dbe_key_sched (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [63:0]                csr_wr_data,
   output dbe_pkg::subkey_array_type       subkeys
);
   import dbe_pkg::*;

   logic [CD_BITS-1:0] cd;
   subkey_array_type   subkeys_in;
   subkey_array_type   subkeys_ff;

   assign cd = perm_pc1(csr_wr_data);

   // Each round's C and D are the PC-1 halves rotated by the running total.
   always_comb begin
      for (int i = 0; i < ROUNDS; i++) begin
         subkeys_in[i] = perm_pc2({rotl28(cd[CD_BITS-1:HALF_KEY_BITS], ROT_SUM_TAB[i]),
                                   rotl28(cd[HALF_KEY_BITS-1:0], ROT_SUM_TAB[i])});
      end
   end

   // A zero key expands to all-zero subkeys, so reset clears them directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         subkeys_ff <= '0;
      end else if (csr_wr_en) begin
         subkeys_ff <= subkeys_in;
      end
   end

   assign subkeys = subkeys_ff;

endmodule
`default_nettype wire

[hdl/dbe_round.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbe_round: one DES Feistel round
// E expansion, subkey mix, eight S-boxes and P permutation on the right half,
// folded into the left half, with the halves exchanged.
// ----------------------------------------------------------------------------
module dbe_round (
   input  wire dbe_pkg::half_pair_type         blk_in,
   input  wire logic [dbe_pkg::SUBKEY_BITS-1:0] subkey,
   output dbe_pkg::half_pair_type              blk_out
);
   import dbe_pkg::*;

   logic [SUBKEY_BITS-1:0] mixed;
   logic [31:0]            sbox_out;

   assign mixed = perm_e(blk_in.right) ^ subkey;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sbox_out[5'(31 - 4*i) -: 4] = sbox(i, mixed[6'(47 - 6*i) -: 6]);
      end
   end

   assign blk_out.left  = blk_in.right;
   assign blk_out.right = blk_in.left ^ perm_p(sbox_out);

endmodule
`default_nettype wire

[hdl/des_block_encrypt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// des_block_encrypt: DES encryption of 64-bit words, one word per cycle
// Usage: write the key through csr_wr_en / csr_wr_data while no word is in
// flight; it is expanded to subkeys at the write and usable the next cycle.
// Parity bits of the key are ignored. After reset the key is all zeros.
// A plaintext word is taken at each clock edge where start is high; busy is
// always low, so a new word may be presented every cycle.
// The word is registered at acceptance, passes all sixteen rounds and the
// final permutation in one combinational pass, and is registered again.
// rsp_valid pulses for one cycle; it follows start through in_valid_ff and rsp_valid_ff.
// Throughput: one word per cycle, set by the input and result registers
// around the round chain. Results are not held: the receiver must take
// rsp_ciphertext in the cycle rsp_valid is high.
// Reset clears the key and drops any words in flight.
// ----------------------------------------------------------------------------
module des_block_encrypt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output wire logic        busy,
   input  wire logic [63:0] req_plaintext,
   output wire logic        rsp_valid,
   output wire logic [63:0] rsp_ciphertext,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data
);
   import dbe_pkg::*;

   subkey_array_type subkeys;
   logic             in_valid_ff;
   half_pair_type    in_blk_in;
   half_pair_type    in_blk_ff;
   half_pair_type    stage [ROUNDS+1];
   logic             rsp_valid_ff;
   logic [63:0]      rsp_ciphertext_in;
   logic [63:0]      rsp_ciphertext_ff;

   dbe_key_sched u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .subkeys     (subkeys)
   );

   assign in_blk_in = perm_ip(req_plaintext);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         in_blk_ff <= in_blk_in;
      end
   end

   assign stage[0] = in_blk_ff;

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      dbe_round u_round (
         .blk_in  (stage[g]),
         .subkey  (subkeys[g]),
         .blk_out (stage[g+1])
      );
   end

   // The last round's exchange is undone before the inverse permutation.
   assign rsp_ciphertext_in = perm_fp({stage[ROUNDS].right, stage[ROUNDS].left});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_ciphertext_ff <= rsp_ciphertext_in;
      end
   end

   assign busy           = 1'b0;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

endmodule
`default_nettype wire
